/* src/wsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_pkg - shared definitions for the windowed sample averager
// Field widths, register indexes, saturation limits and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wsa_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int COUNT_WIDTH  = 16;
    localparam int TICK_WIDTH   = 16;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int STEP_W       = $clog2(SUM_WIDTH);

    localparam logic [TICK_WIDTH-1:0] WINDOW_RESET = TICK_WIDTH'(1000);

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX_BITS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN_BITS = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SUM_WIDTH-1:0]    SUM_MAX_BITS    = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0]    SUM_MIN_BITS    = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_TICKS   = 1'b0,
        REG_MAGNITUDE_MODE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic acc_en;    // take one tick word
        logic div_prep;  // split sign and magnitude of the window sum
        logic div_step;  // one quotient bit
        logic out_load;  // saturate quotient into the output register
    } t_cmd;

    typedef struct packed {
        logic win_close; // current tick word ends the window
        logic div_last;  // divider is on its final bit
        logic out_busy;  // output register holds a word not taken this cycle
    } t_sts;

endpackage

/* src/wsa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_ctrl - sequencer for the windowed sample averager
// Runs ticks into the accumulator, then walks the bit-serial divider when a
// window closes and hands the result to the output register.
// ----------------------------------------------------------------------------
module wsa_ctrl
    import wsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_sts.win_close) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.div_prep = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the quotient until the output register frees up
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_DONE))
        else $error("divider finished without reaching the result state");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("output register overwritten while a word is pending");

endmodule

/* src/wsa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_dp - datapath for the windowed sample averager
// Configuration registers, saturating sum and count, tick counter, a
// restoring divider that makes one quotient bit per cycle, and the output
// register.
// ----------------------------------------------------------------------------
module wsa_dp
    import wsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]    i_cfg_data,
    input  logic                    i_sample_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_out_ready,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic [SAMPLE_WIDTH-1:0] o_average,
    output logic [COUNT_WIDTH-1:0]  o_samples_used
);

    logic [TICK_WIDTH-1:0]   r_window;
    logic                    r_mag;
    logic [SUM_WIDTH-1:0]    r_sum;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [TICK_WIDTH-1:0]   r_elapsed;
    logic [SUM_WIDTH-1:0]    r_quo;
    logic [COUNT_WIDTH-1:0]  r_rem;
    logic [COUNT_WIDTH-1:0]  r_den;
    logic [COUNT_WIDTH-1:0]  r_snap_count;
    logic                    r_neg;
    logic [STEP_W-1:0]       r_step;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_average;
    logic [COUNT_WIDTH-1:0]  r_samples_used;

    logic [SAMPLE_WIDTH-1:0] s_val;
    logic [SUM_WIDTH:0]      sum_wide;
    logic [SUM_WIDTH-1:0]    n_sum;
    logic [COUNT_WIDTH-1:0]  n_count;
    logic [TICK_WIDTH-1:0]   n_elapsed;
    logic [COUNT_WIDTH:0]    rem_sh;
    logic                    rem_ge;
    logic [SAMPLE_WIDTH-1:0] n_average;

    // magnitude mode folds negative samples, most negative one clips to max
    always_comb begin
        s_val = i_sample;
        if (r_mag && i_sample[SAMPLE_WIDTH-1]) begin
            s_val = (i_sample == SAMPLE_MIN_BITS) ? SAMPLE_MAX_BITS : (~i_sample + 1'b1);
        end
    end

    always_comb begin
        sum_wide = {r_sum[SUM_WIDTH-1], r_sum}
                 + {{(SUM_WIDTH+1-SAMPLE_WIDTH){s_val[SAMPLE_WIDTH-1]}}, s_val};
        n_sum   = r_sum;
        n_count = r_count;
        if (i_sample_valid) begin
            if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
                n_sum = sum_wide[SUM_WIDTH] ? SUM_MIN_BITS : SUM_MAX_BITS;
            end else begin
                n_sum = sum_wide[SUM_WIDTH-1:0];
            end
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
        n_elapsed = (r_elapsed != '1) ? (r_elapsed + 1'b1) : r_elapsed;
    end

    assign rem_sh = {r_rem, r_quo[SUM_WIDTH-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});

    // clip the quotient back into the sample range and restore the sign
    always_comb begin
        if (r_neg) begin
            if (r_quo > {{(SUM_WIDTH-SAMPLE_WIDTH){1'b0}}, SAMPLE_MIN_BITS}) begin
                n_average = SAMPLE_MIN_BITS;
            end else begin
                n_average = ~r_quo[SAMPLE_WIDTH-1:0] + 1'b1;
            end
        end else begin
            if (r_quo > {{(SUM_WIDTH-SAMPLE_WIDTH){1'b0}}, SAMPLE_MAX_BITS}) begin
                n_average = SAMPLE_MAX_BITS;
            end else begin
                n_average = r_quo[SAMPLE_WIDTH-1:0];
            end
        end
    end

    assign o_sts.win_close = (n_elapsed >= r_window);
    assign o_sts.div_last  = (r_step == '0);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_mag       <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_elapsed   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_WINDOW_TICKS:   r_window <= i_cfg_data[TICK_WIDTH-1:0];
                    REG_MAGNITUDE_MODE: r_mag    <= i_cfg_data[0];
                    default:            r_mag    <= r_mag;
                endcase
            end
            if (i_cmd.acc_en) begin
                if (o_sts.win_close) begin
                    r_sum     <= '0;
                    r_count   <= '0;
                    r_elapsed <= '0;
                end else begin
                    r_sum     <= n_sum;
                    r_count   <= n_count;
                    r_elapsed <= n_elapsed;
                end
            end
            if (i_cmd.div_prep) begin
                r_step <= STEP_W'(SUM_WIDTH - 1);
            end else if (i_cmd.div_step) begin
                r_step <= r_step - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en && o_sts.win_close) begin
            r_quo        <= n_sum;
            r_snap_count <= n_count;
        end else if (i_cmd.div_prep) begin
            r_neg <= r_quo[SUM_WIDTH-1];
            r_quo <= r_quo[SUM_WIDTH-1] ? (~r_quo + 1'b1) : r_quo;
            r_rem <= '0;
            r_den <= (r_snap_count == '0) ? COUNT_WIDTH'(1) : r_snap_count;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? COUNT_WIDTH'(rem_sh - {1'b0, r_den})
                            : rem_sh[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[SUM_WIDTH-2:0], rem_ge};
        end
        if (i_cmd.out_load) begin
            r_average      <= n_average;
            r_samples_used <= r_snap_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_average      = r_average;
    assign o_samples_used = r_samples_used;

    a_window_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc_en && o_sts.win_close)
        |=> (r_sum == '0 && r_count == '0 && r_elapsed == '0))
        else $error("accumulators not cleared at window end");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder reached the divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den != '0))
        else $error("divider running with a zero divisor");

    a_out_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

/* src/windowed_sample_averager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_averager_unit - boxcar average over a tick window
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-------------------------------
//   tick in  | i_in_valid   | o_in_ready   | i_sample_valid, i_sample
//   avg out  | o_out_valid  | i_out_ready  | o_average, o_samples_used
//   config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// A tick word that does not close the window keeps the block in its run state.
// A closing tick holds off the next tick word while the block first splits the
// sign, then the restoring divider yields one quotient bit per cycle, then the
// result is clipped into the output register.
// If the previous average still sits in the output register, the loading
// cycle waits until it is taken.
// Reset is synchronous: window 1000 ticks, signed mode, all counters zero.
// ----------------------------------------------------------------------------
module windowed_sample_averager_unit
    import wsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_sample_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [SAMPLE_WIDTH-1:0] o_average,
    output logic [COUNT_WIDTH-1:0]  o_samples_used
);

    t_cmd cmd;
    t_sts sts;

    wsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    wsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .i_sample       (i_sample),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_average      (o_average),
        .o_samples_used (o_samples_used)
    );

endmodule

/* sim/windowed_sample_averager_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_averager_unit_tb - self-checking bench for the tick averager
// Drives tick words with bursty timing and reprograms the window length and
// the magnitude mode between phases. A local model folds every accepted
// tick and predicts each window average. The output side stalls on its own
// pattern and holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module windowed_sample_averager_unit_tb;
    import wsa_pkg::*;

    localparam int          DRAIN_CYCLES = SUM_WIDTH + 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int          RANDOM_TICKS = 700;

    localparam longint SUM_HI    = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] average;
        logic [COUNT_WIDTH-1:0]  used;
    } t_window_avg;

    typedef enum logic [1:0] {
        ROW_WINDOW,
        ROW_MODE,
        ROW_TICK
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic                    sv;
        logic [SAMPLE_WIDTH-1:0] val;
        logic                    fixed_exp;
        logic [SAMPLE_WIDTH-1:0] t_avg;
        logic [COUNT_WIDTH-1:0]  t_used;
    } t_script_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_WIDTH-1:0]    i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_sample_valid;
    logic [SAMPLE_WIDTH-1:0] i_sample;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [SAMPLE_WIDTH-1:0] o_average;
    logic [COUNT_WIDTH-1:0]  o_samples_used;

    // window model state
    longint                  acc_sum       = 0;
    logic [COUNT_WIDTH-1:0]  acc_count     = '0;
    logic [TICK_WIDTH-1:0]   tick_count    = '0;
    logic [TICK_WIDTH-1:0]   cfg_window    = WINDOW_RESET;
    logic                    cfg_magnitude = 1'b0;

    t_window_avg expected_averages [$];
    int unsigned burst_left       = 0;
    int unsigned ticks_sent       = 0;
    int unsigned averages_checked = 0;
    int unsigned errors           = 0;
    logic        hold_go          = 1'b0;

    // Ticks with a typed expectation follow directly from the window rules.
    t_script_row script [26] = '{
        '{ROW_WINDOW, 1'b0, 16'd1,           1'b0, 16'd0,           16'd0},
        '{ROW_MODE,   1'b0, 16'd0,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b0, 16'd0,           1'b1, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, SAMPLE_MAX_BITS, 1'b1, SAMPLE_MAX_BITS, 16'd1},
        '{ROW_TICK,   1'b1, SAMPLE_MIN_BITS, 1'b1, SAMPLE_MIN_BITS, 16'd1},
        '{ROW_TICK,   1'b1, 16'hFFFF,        1'b1, 16'hFFFF,        16'd1},
        '{ROW_TICK,   1'b0, SAMPLE_MIN_BITS, 1'b1, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'd0,           1'b1, 16'd0,           16'd1},
        '{ROW_MODE,   1'b0, 16'd1,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, SAMPLE_MIN_BITS, 1'b1, SAMPLE_MAX_BITS, 16'd1},
        '{ROW_TICK,   1'b1, 16'hFFFB,        1'b1, 16'd5,           16'd1},
        '{ROW_TICK,   1'b1, SAMPLE_MAX_BITS, 1'b1, SAMPLE_MAX_BITS, 16'd1},
        '{ROW_WINDOW, 1'b0, 16'd0,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'h8001,        1'b1, SAMPLE_MAX_BITS, 16'd1},
        '{ROW_TICK,   1'b0, 16'hFFFF,        1'b1, 16'd0,           16'd0},
        '{ROW_WINDOW, 1'b0, 16'd3,           1'b0, 16'd0,           16'd0},
        '{ROW_MODE,   1'b0, 16'd0,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'd7,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'hFFFE,        1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b0, 16'h5555,        1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'hFFF9,        1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'd0,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, 16'd0,           1'b0, 16'd0,           16'd0},
        '{ROW_WINDOW, 1'b0, 16'd2,           1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, SAMPLE_MIN_BITS, 1'b0, 16'd0,           16'd0},
        '{ROW_TICK,   1'b1, SAMPLE_MIN_BITS, 1'b0, 16'd0,           16'd0}
    };

    windowed_sample_averager_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_valid (i_sample_valid),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_average      (o_average),
        .o_samples_used (o_samples_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fold one tick into the window; report the average when it closes.
    function automatic void fold_tick(input logic sv, input logic [SAMPLE_WIDTH-1:0] raw,
                                      output bit closes, output t_window_avg res);
        longint v;
        longint q;
        closes = 1'b0;
        res    = '0;
        if (sv) begin
            v = longint'($signed(raw));
            if (cfg_magnitude && v < 0) begin
                v = (v == SAMPLE_LO) ? SAMPLE_HI : -v;
            end
            if (v > 0 && acc_sum > SUM_HI - v) begin
                acc_sum = SUM_HI;
            end else if (v < 0 && acc_sum < SUM_LO - v) begin
                acc_sum = SUM_LO;
            end else begin
                acc_sum = acc_sum + v;
            end
            if (acc_count != '1) begin
                acc_count = acc_count + 1'b1;
            end
        end
        if (tick_count != '1) begin
            tick_count = tick_count + 1'b1;
        end
        if (tick_count >= cfg_window) begin
            q = acc_sum / ((acc_count == '0) ? longint'(1) : longint'(acc_count));
            if (q > SAMPLE_HI) q = SAMPLE_HI;
            if (q < SAMPLE_LO) q = SAMPLE_LO;
            closes      = 1'b1;
            res.average = q[SAMPLE_WIDTH-1:0];
            res.used    = acc_count;
            acc_sum     = 0;
            acc_count   = '0;
            tick_count  = '0;
        end
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MAX_BITS;
            1:       return SAMPLE_MIN_BITS;
            2:       return SAMPLE_WIDTH'($urandom_range(0, 40)) - SAMPLE_WIDTH'(20);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Drop valid, wait for every pending average, then let the divider go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_WIDTH-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_TICKS:   cfg_window = data[TICK_WIDTH-1:0];
            REG_MAGNITUDE_MODE: cfg_magnitude = data[0];
            default:            ;
        endcase
    endtask

    task automatic send_tick(input logic sv, input logic [SAMPLE_WIDTH-1:0] s,
                             input logic fixed_exp, input logic [SAMPLE_WIDTH-1:0] t_avg,
                             input logic [COUNT_WIDTH-1:0] t_used);
        int unsigned gap;
        bit          closes;
        t_window_avg res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(13, 50);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_sample_valid <= sv;
        i_sample       <= s;
        do @(posedge i_clk); while (!o_in_ready);
        fold_tick(sv, s, closes, res);
        if (closes) begin
            if (fixed_exp) res = '{average: t_avg, used: t_used};
            expected_averages.push_back(res);
        end
        ticks_sent++;
    endtask

    initial begin : stimulus
        int unsigned random_ticks;
        int unsigned phase;
        int unsigned density;
        int unsigned n;
        logic [CFG_WIDTH-1:0] win;
        random_ticks = 0;
        phase        = 0;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_WINDOW_TICKS;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_sample_valid <= 1'b0;
        i_sample       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_WINDOW: write_reg(REG_WINDOW_TICKS, script[i].val);
                ROW_MODE:   write_reg(REG_MAGNITUDE_MODE, script[i].val);
                default:    send_tick(script[i].sv, script[i].val, script[i].fixed_exp,
                                      script[i].t_avg, script[i].t_used);
            endcase
        end

        while (random_ticks < RANDOM_TICKS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: win = CFG_WIDTH'($urandom_range(1, 8));
                6, 7:             win = CFG_WIDTH'($urandom_range(9, 40));
                default:          win = CFG_WIDTH'($urandom_range(100, 400));
            endcase
            if (phase == 3) win = CFG_WIDTH'(1);
            write_reg(REG_WINDOW_TICKS, win);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_MAGNITUDE_MODE, CFG_WIDTH'($urandom_range(0, 1)));
            end
            case ($urandom_range(0, 3))
                0:       density = 100;
                1:       density = 30;
                2:       density = 0;
                default: density = 80;
            endcase
            // hold the output off once while every tick closes a window
            if (phase == 3) hold_go <= 1'b1;
            n = $urandom_range(30, 80);
            repeat (n) begin
                send_tick($urandom_range(0, 99) < density, pick_sample(), 1'b0, '0, '0);
                random_ticks++;
            end
            phase++;
        end

        settle();
        $display("ran %0d ticks: directed rows plus %0d random phases of window and mode",
                 ticks_sent, phase);
        $display("checked %0d window averages in signed and magnitude mode", averages_checked);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : average_sink
        int unsigned pat_left;
        int unsigned pat_mode;
        int unsigned hold_left;
        bit          hold_done;
        logic        nxt;
        t_window_avg want;
        pat_left  = 0;
        pat_mode  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_averages.size() == 0) begin
                    $display("%0t: unexpected word avg %0d used %0d", $time,
                             $signed(o_average), o_samples_used);
                    errors++;
                end else begin
                    want = expected_averages.pop_front();
                    averages_checked++;
                    if (o_average !== want.average) begin
                        $display("%0t: average expected %0d got %0d", $time,
                                 $signed(want.average), $signed(o_average));
                        errors++;
                    end
                    if (o_samples_used !== want.used) begin
                        $display("%0t: samples_used expected %0d got %0d", $time,
                                 want.used, o_samples_used);
                        errors++;
                    end
                end
            end
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (pat_left == 0) begin
                pat_left = $urandom_range(20, 120);
                pat_mode = $urandom_range(0, 2);
            end
            pat_left--;
            if (hold_left != 0) begin
                hold_left--;
                nxt = 1'b0;
            end else begin
                case (pat_mode)
                    0:       nxt = 1'b1;
                    1:       nxt = $urandom_range(0, 1);
                    default: nxt = ($urandom_range(0, 4) == 0);
                endcase
            end
            i_out_ready <= nxt;
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/wsa_pkg.sv
src/wsa_ctrl.sv
src/wsa_dp.sv
src/windowed_sample_averager_unit.sv
sim/windowed_sample_averager_unit_tb.sv
